### hdl/assert_macros.svh
// assertion helpers for the rtl file timed_actuator_travel_fsm
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// expression that must never be true while out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### hdl/tatf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tatf_pkg
// types and constants for the timed actuator travel controller
// ----------------------------------------------------------------------------
package tatf_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int ELAPSED_W  = 32;
	localparam int TRAVEL_W   = 31;
	localparam int DWELL_W    = 32;
	localparam int CFG_W      = 32;
	// wide enough for any operand plus one carry bit
	localparam int SUM_W      = ((TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W) + 1;

	localparam logic [TIME_WIDTH-1:0] TIMER_MAX = '1;
	localparam logic [DWELL_W-1:0]    DWELL_DISABLED = '1;

	typedef enum logic [1:0] {
		CFG_TRAVEL_ON  = 2'd0,
		CFG_TRAVEL_OFF = 2'd1,
		CFG_ON_DWELL   = 2'd2,
		CFG_OFF_DWELL  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_ON   = 2'd1,
		KIND_OFF  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_OFF      = 2'd0,
		PH_TRAV_ON  = 2'd1,
		PH_ON       = 2'd2,
		PH_TRAV_OFF = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_TRAV_ON  = 3'd1,
		EV_TRAV_OFF = 3'd2,
		EV_AT_ON    = 3'd3,
		EV_AT_OFF   = 3'd4
	} event_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ELAPSED_W-1:0]  elapsed_us;
	} in_word_t;

	typedef struct packed {
		logic   drive_level;
		phase_t phase;
		event_t event_res;
	} out_word_t;

endpackage
`default_nettype wire

### hdl/timed_actuator_travel_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_actuator_travel_fsm
// four-phase actuator controller: travel on, on, travel off, off
// ----------------------------------------------------------------------------
// Takes one word per clock while out_stall does not hold the output and
// returns one result word for every input word, in order. A word is
// registered on acceptance, evaluated against the phase and phase timer and
// written to the output register; the phase and timer update on that same
// edge, which keeps the next word in the input register seeing the new state
// and sustains one word per cycle. Only out_stall slows the block: a held
// output register holds the input register, and in_stall then rises. Ticks
// compare the timer with the travel or dwell time of the current phase,
// advance at most one phase, then add elapsed_us with saturation at the timer
// maximum. Dwell registers with the sign bit set (nominally -1) disable the
// automatic switch. The user must write configuration through cfg_we /
// cfg_index / cfg_data while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_actuator_travel_fsm (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input channel
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire tatf_pkg::in_word_t     in_data,
	// output channel
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      tatf_pkg::out_word_t    out_data,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire tatf_pkg::cfg_index_t   cfg_index,
	input  wire logic [tatf_pkg::CFG_W-1:0] cfg_data
);
	import tatf_pkg::*;

	// configuration registers
	logic [TRAVEL_W-1:0]   travel_on_q;
	logic [TRAVEL_W-1:0]   travel_off_q;
	logic [DWELL_W-1:0]    on_dwell_q;
	logic [DWELL_W-1:0]    off_dwell_q;

	// input register
	logic                  valid_s1;
	in_word_t              data_s1;

	// controller state
	phase_t                phase_q;
	phase_t                phase_next;
	logic [TIME_WIDTH-1:0] timer_q;
	logic [TIME_WIDTH-1:0] timer_next;
	event_t                event_next;

	// handshake
	logic                  out_free;
	logic                  adv_s1;
	logic                  take_in;

	// phase checks
	logic                  travel_on_done;
	logic                  travel_off_done;
	logic                  on_dwell_done;
	logic                  off_dwell_done;
	logic                  is_on;
	logic [TIME_WIDTH-1:0] timer_mid;
	logic [SUM_W-1:0]      timer_sum;

	// ------------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_on_q  <= '0;
			travel_off_q <= '0;
			on_dwell_q   <= DWELL_DISABLED;
			off_dwell_q  <= DWELL_DISABLED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRAVEL_ON:  travel_on_q  <= cfg_data[TRAVEL_W-1:0];
				CFG_TRAVEL_OFF: travel_off_q <= cfg_data[TRAVEL_W-1:0];
				CFG_ON_DWELL:   on_dwell_q   <= cfg_data[DWELL_W-1:0];
				CFG_OFF_DWELL:  off_dwell_q  <= cfg_data[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// handshake: output register frees when empty or taken this cycle,
	// input register moves on whenever the output register can take it
	// ------------------------------------------------------------------------
	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= in_data;
		end
	end

	// ------------------------------------------------------------------------
	// phase checks against the current timer
	// ------------------------------------------------------------------------
	assign travel_on_done  = SUM_W'(timer_q) >= SUM_W'(travel_on_q);
	assign travel_off_done = SUM_W'(timer_q) >= SUM_W'(travel_off_q);
	// sign bit set disables the dwell
	assign on_dwell_done   = !on_dwell_q[DWELL_W-1]
		&& (SUM_W'(timer_q) >= SUM_W'(on_dwell_q[DWELL_W-2:0]));
	assign off_dwell_done  = !off_dwell_q[DWELL_W-1]
		&& (SUM_W'(timer_q) >= SUM_W'(off_dwell_q[DWELL_W-2:0]));
	assign is_on = (phase_q == PH_TRAV_ON) || (phase_q == PH_ON);

	// ------------------------------------------------------------------------
	// next phase
	// ------------------------------------------------------------------------
	always_comb begin
		phase_next = phase_q;
		unique case (data_s1.kind)
			KIND_TICK: begin
				unique case (phase_q)
					PH_TRAV_ON:  if (travel_on_done)  phase_next = PH_ON;
					PH_ON:       if (on_dwell_done)   phase_next = PH_TRAV_OFF;
					PH_TRAV_OFF: if (travel_off_done) phase_next = PH_OFF;
					PH_OFF:      if (off_dwell_done)  phase_next = PH_TRAV_ON;
					default:     phase_next = phase_q;
				endcase
			end
			KIND_ON:  if (!is_on) phase_next = PH_TRAV_ON;
			KIND_OFF: if (is_on)  phase_next = PH_TRAV_OFF;
			default:  phase_next = phase_q;
		endcase
	end

	// ------------------------------------------------------------------------
	// event code and timer update
	// ------------------------------------------------------------------------
	always_comb begin
		event_next = EV_NONE;
		timer_mid  = timer_q;
		timer_sum  = '0;
		timer_next = timer_q;
		unique case (data_s1.kind)
			KIND_TICK: begin
				unique case (phase_q)
					PH_TRAV_ON: if (travel_on_done) begin
						event_next = EV_AT_ON;
						timer_mid  = '0;
					end
					PH_ON: if (on_dwell_done) begin
						// dwell ran out: switch off automatically
						event_next = EV_TRAV_OFF;
						timer_mid  = '0;
					end
					PH_TRAV_OFF: if (travel_off_done) begin
						event_next = EV_AT_OFF;
						timer_mid  = '0;
					end
					PH_OFF: if (off_dwell_done) begin
						event_next = EV_TRAV_ON;
						timer_mid  = '0;
					end
					default: event_next = EV_NONE;
				endcase
				// add elapsed time, saturating at the timer maximum
				timer_sum = SUM_W'(timer_mid) + SUM_W'(data_s1.elapsed_us);
				if (timer_sum > SUM_W'(TIMER_MAX)) begin
					timer_next = TIMER_MAX;
				end else begin
					timer_next = timer_sum[TIME_WIDTH-1:0];
				end
			end
			KIND_ON: if (!is_on) begin
				event_next = EV_TRAV_ON;
				timer_next = '0;
			end
			KIND_OFF: if (is_on) begin
				event_next = EV_TRAV_OFF;
				timer_next = '0;
			end
			default: event_next = EV_NONE;
		endcase
	end

	// ------------------------------------------------------------------------
	// state and output register, both advance with the input register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF;
			timer_q <= '0;
		end else if (adv_s1) begin
			phase_q <= phase_next;
			timer_q <= timer_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data.drive_level <= (phase_next == PH_TRAV_ON) || (phase_next == PH_ON);
			out_data.phase       <= phase_next;
			out_data.event_res   <= event_next;
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	`ASSERT_CLK(a_level_follows_phase, out_valid |-> (out_data.drive_level == ((out_data.phase == PH_TRAV_ON) || (out_data.phase == PH_ON))), "drive level disagrees with phase")
	`ASSERT_CLK(a_trav_on_event_phase, (out_valid && (out_data.event_res == EV_TRAV_ON)) |-> (out_data.phase == PH_TRAV_ON), "travel on event without travel on phase")
	`ASSERT_CLK(a_state_holds_idle, !adv_s1 |=> ($stable(phase_q) && $stable(timer_q)), "state changed without a word")
	`ASSERT_NEVER(a_stall_needs_word, in_stall && !valid_s1, "input stalled with empty input register")

endmodule
`default_nettype wire
